[rtl/core/tss_pkg.sv]
// Types and constants for the token scanner with statement split.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
package tss_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [7:0]  lead_char;
      logic [31:0] start_offset;
      logic [31:0] token_length;
      logic        has_point;
      logic [31:0] point_offset;
      logic        opens_statement;
      logic [2:0]  error_code;
      logic        stream_clean;
      logic        last_of_run;
   } rsp_type;

   localparam logic [3:0] K_EQUAL  = 4'd0;
   localparam logic [3:0] K_ARITH  = 4'd1;
   localparam logic [3:0] K_SEP    = 4'd2;
   localparam logic [3:0] K_POPEN  = 4'd3;
   localparam logic [3:0] K_PCLOSE = 4'd4;
   localparam logic [3:0] K_BOPEN  = 4'd5;
   localparam logic [3:0] K_BCLOSE = 4'd6;
   localparam logic [3:0] K_BAR    = 4'd7;
   localparam logic [3:0] K_IDENT  = 4'd8;
   localparam logic [3:0] K_NAME   = 4'd9;
   localparam logic [3:0] K_LIT    = 4'd10;
   localparam logic [3:0] K_ERROR  = 4'd11;

   localparam logic [2:0] E_NONE     = 3'd0;
   localparam logic [2:0] E_EQ_FIRST = 3'd1;
   localparam logic [2:0] E_COMMENT  = 3'd2;
   localparam logic [2:0] E_UNKNOWN  = 3'd3;
   localparam logic [2:0] E_UNTERM   = 3'd4;

   localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

   typedef enum logic [6:0] {
      MODE_NORMAL = 7'b0000001,
      MODE_HASH   = 7'b0000010,
      MODE_LINE   = 7'b0000100,
      MODE_BLOCK  = 7'b0001000,
      MODE_IDENT  = 7'b0010000,
      MODE_NAME   = 7'b0100000,
      MODE_LIT    = 7'b1000000
   } mode_type;

   // Up to four results per byte, built by the front end, drained by the back.
   typedef struct packed {
      logic [3:0] valid;
      rsp_type    r0;
      rsp_type    r1;
      rsp_type    r2;
      rsp_type    r3;
   } bundle_type;

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_BOPEN  = 8'h7B;
   localparam logic [7:0] CH_BCLOSE = 8'h7D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_POPEN  = 8'h28;
   localparam logic [7:0] CH_PCLOSE = 8'h29;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return (c == 8'h5F) || is_alpha(c) || is_digit(c);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic [31:0] sat_len(input logic [31:0] v);
      return (v == LEN_MAX) ? LEN_MAX : v + 32'd1;
   endfunction

endpackage

[rtl/core/tss_front.sv]
// Front end: scanner state machine, classifies one byte per cycle while step is high into a result bundle.
// Depends on tss_pkg.
`timescale 1ns / 1ps
module tss_front #(
   parameter int POSITION_BITS = 32,
   parameter int DEPTH_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  tss_pkg::req_type    req,
   output tss_pkg::bundle_type bundle
);
   import tss_pkg::*;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

   mode_type              mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [31:0] pstart_ff, pstart_in, plen_ff, plen_in, ppt_ff, ppt_in;
   logic        php_ff, php_in;
   logic [7:0]  plead_ff, plead_in;
   logic        brace_ff, brace_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        err_ff, err_in;
   logic        hv_ff, hv_in;
   rsp_type     held_ff, held_in;

   logic [7:0]  c;
   logic        fin;
   logic [31:0] p;
   rsp_type     res [4];
   logic [2:0]  n;

   assign c   = req.text_byte;
   assign fin = req.final_byte;

   always_comb begin
      rsp_type t;
      logic    do_normal;
      logic    do_finish;
      logic    push;
      logic [3:0] pk;
      logic [3:0] fk;
      logic [2:0] k;

      p = 32'(pos_ff);
      mode_in = mode_ff; pos_in = pos_ff + 1'b1; depth_in = depth_ff;
      pstart_in = pstart_ff; plen_in = plen_ff; ppt_in = ppt_ff; php_in = php_ff;
      plead_in = plead_ff; brace_in = brace_ff; cnt_in = cnt_ff; err_in = err_ff;
      hv_in = hv_ff; held_in = held_ff;
      n = '0;
      for (int i = 0; i < 4; i++) res[i] = '0;
      do_normal = 1'b0; do_finish = 1'b0; push = 1'b0; pk = K_EQUAL;
      t = '0;

      case (mode_ff)
         MODE_HASH: begin
            if (c == CH_HASH) mode_in = MODE_LINE;
            else if (c == CH_POPEN) begin
               mode_in = MODE_BLOCK; depth_in = DEPTH_BITS'(1);
            end else begin
               mode_in = MODE_NORMAL;
               err_in = 1'b1;
               res[n[1:0]] = '0; res[n[1:0]].token_kind = K_ERROR;
               res[n[1:0]].lead_char = c; res[n[1:0]].start_offset = p;
               res[n[1:0]].error_code = E_COMMENT; n = n + 3'd1;
            end
         end
         MODE_LINE: if (c == CH_NL) mode_in = MODE_NORMAL;
         MODE_BLOCK: begin
            if (c == CH_POPEN) begin
               if (depth_ff < DEPTH_MAX) depth_in = depth_ff + 1'b1;
            end else if (c == CH_PCLOSE) begin
               if (depth_ff != '0) depth_in = depth_ff - 1'b1;
               if (depth_in == '0) mode_in = MODE_NORMAL;
            end
         end
         MODE_IDENT, MODE_NAME: begin
            if (is_word(c)) plen_in = sat_len(plen_ff);
            else begin do_finish = 1'b1; do_normal = 1'b1; end
         end
         MODE_LIT: begin
            if (c == CH_DOT && !php_ff) begin
               php_in = 1'b1; ppt_in = plen_ff; plen_in = sat_len(plen_ff);
            end else if (is_digit(c)) plen_in = sat_len(plen_ff);
            else begin do_finish = 1'b1; do_normal = 1'b1; end
         end
         default: do_normal = 1'b1;
      endcase

      fk = (mode_ff == MODE_IDENT) ? K_IDENT : (mode_ff == MODE_NAME) ? K_NAME : K_LIT;
      // Up to two token pushes per byte: the finished pending token, then the byte's own.
      for (int s = 0; s < 2; s++) begin
         push = 1'b0;
         if (s == 0 && (do_finish || (fin && !do_normal && (mode_in == MODE_IDENT ||
             mode_in == MODE_NAME || mode_in == MODE_LIT)))) begin
            push = 1'b1;
            t = '0;
            t.token_kind = do_finish ? fk :
               (mode_in == MODE_IDENT) ? K_IDENT : (mode_in == MODE_NAME) ? K_NAME : K_LIT;
            t.lead_char = plead_in; t.start_offset = pstart_in; t.token_length = plen_in;
            t.has_point = (t.token_kind == K_LIT) ? php_in : 1'b0;
            t.point_offset = t.has_point ? ppt_in : 32'd0;
            if (!do_finish) mode_in = MODE_NORMAL;
         end
         if (s == 1 && do_normal) begin
            mode_in = MODE_NORMAL;
            t = '0; t.lead_char = c; t.start_offset = p; t.token_length = 32'd1;
            pk = K_EQUAL;
            case (c)
               CH_HASH: mode_in = MODE_HASH;
               CH_EQ: begin push = 1'b1; pk = K_EQUAL; end
               8'h2B, 8'h2D, 8'h2A, 8'h2F: begin push = 1'b1; pk = K_ARITH; end
               CH_COMMA, CH_SEMI: begin push = 1'b1; pk = K_SEP; end
               CH_POPEN: begin push = 1'b1; pk = K_POPEN; end
               CH_PCLOSE: begin push = 1'b1; pk = K_PCLOSE; end
               CH_BOPEN: begin push = 1'b1; pk = K_BOPEN; brace_in = 1'b1; end
               CH_BCLOSE: begin push = 1'b1; pk = K_BCLOSE; brace_in = 1'b0; end
               CH_BAR: begin push = 1'b1; pk = K_BAR; end
               default: begin
                  if (is_alpha(c) || c == CH_PCT || c == CH_DOT || is_digit(c)) begin
                     mode_in = is_alpha(c) ? MODE_IDENT : (c == CH_PCT) ? MODE_NAME : MODE_LIT;
                     plead_in = c; pstart_in = p; plen_in = 32'd1;
                     php_in = (c == CH_DOT) && !is_alpha(c); ppt_in = 32'd0;
                     if (fin) begin
                        push = 1'b1;
                        t.token_kind = is_alpha(c) ? K_IDENT : (c == CH_PCT) ? K_NAME : K_LIT;
                        t.has_point = (c == CH_DOT);
                        mode_in = MODE_NORMAL;
                     end
                  end else if (!is_space(c)) begin
                     err_in = 1'b1;
                     res[n[1:0]] = '0; res[n[1:0]].token_kind = K_ERROR;
                     res[n[1:0]].lead_char = c; res[n[1:0]].start_offset = p;
                     res[n[1:0]].error_code = E_UNKNOWN;
                     n = n + 3'd1;
                  end
               end
            endcase
            if (push && !(fin && t.token_kind != K_EQUAL && c != CH_EQ &&
                (is_alpha(c) || c == CH_PCT || c == CH_DOT || is_digit(c))))
               t.token_kind = pk;
         end
         if (push) begin
            if (t.token_kind == K_EQUAL && !brace_in) begin
               if (cnt_in == 2'd0) begin
                  err_in = 1'b1;
                  res[n[1:0]] = '0; res[n[1:0]].token_kind = K_ERROR;
                  res[n[1:0]].lead_char = t.lead_char;
                  res[n[1:0]].start_offset = t.start_offset;
                  res[n[1:0]].error_code = E_EQ_FIRST;
                  n = n + 3'd1;
               end else if (cnt_in == 2'd2) begin
                  if (hv_in) held_in.opens_statement = 1'b1;
                  cnt_in = 2'd1;
               end
            end
            t.opens_statement = (cnt_in == 2'd0);
            if (hv_in) begin res[n[1:0]] = held_in; n = n + 3'd1; end
            hv_in = 1'b1; held_in = t;
            if (cnt_in != 2'd2) cnt_in = cnt_in + 2'd1;
         end
      end

      if (fin) begin
         if (mode_in == MODE_BLOCK && depth_in != '0) begin
            err_in = 1'b1;
            res[n[1:0]] = '0; res[n[1:0]].token_kind = K_ERROR; res[n[1:0]].lead_char = c;
            res[n[1:0]].start_offset = p; res[n[1:0]].error_code = E_UNTERM;
            n = n + 3'd1;
         end
         if (hv_in) begin res[n[1:0]] = held_in; n = n + 3'd1; end
         for (int i = 0; i < 4; i++) res[i].stream_clean = !err_in;
         mode_in = MODE_NORMAL; pos_in = '0; depth_in = '0; pstart_in = '0;
         plen_in = '0; ppt_in = '0; php_in = 1'b0; plead_in = '0; brace_in = 1'b0;
         cnt_in = '0; err_in = 1'b0; hv_in = 1'b0;
      end
      k = n - 3'd1;
      if (n != 3'd0) res[k[1:0]].last_of_run = 1'b1;
   end

   always_comb begin
      bundle.r0 = res[0]; bundle.r1 = res[1]; bundle.r2 = res[2]; bundle.r3 = res[3];
      bundle.valid[0] = (n > 3'd0);
      bundle.valid[1] = (n > 3'd1);
      bundle.valid[2] = (n > 3'd2);
      bundle.valid[3] = (n > 3'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL; pos_ff <= '0; depth_ff <= '0; pstart_ff <= '0;
         plen_ff <= '0; ppt_ff <= '0; php_ff <= 1'b0; plead_ff <= '0;
         brace_ff <= 1'b0; cnt_ff <= '0; err_ff <= 1'b0; hv_ff <= 1'b0;
         held_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in; pos_ff <= pos_in; depth_ff <= depth_in;
         pstart_ff <= pstart_in; plen_ff <= plen_in; ppt_ff <= ppt_in; php_ff <= php_in;
         plead_ff <= plead_in; brace_ff <= brace_in; cnt_ff <= cnt_in; err_ff <= err_in;
         hv_ff <= hv_in; held_ff <= held_in;
      end
   end
endmodule

[rtl/core/tss_back.sv]
// Back end: queue of result bundles, drained one result per pop.
// Depends on tss_pkg.
`timescale 1ns / 1ps
module tss_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr,
   input  tss_pkg::bundle_type wdata,
   output logic                full,
   output logic                empty,
   output tss_pkg::rsp_type    rsp,
   input  logic                pop
);
   import tss_pkg::*;

   bundle_type mem_ff [4];
   logic [2:0] wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] sub_ff, sub_in;
   bundle_type head;
   logic       has_any;
   logic       more;

   assign has_any = (wp_ff != rp_ff);
   assign head    = mem_ff[rp_ff[1:0]];
   assign full    = (wp_ff[1:0] == rp_ff[1:0]) && (wp_ff[2] != rp_ff[2]);
   assign empty   = !has_any;

   always_comb begin
      case (sub_ff)
         2'd0: rsp = head.r0;
         2'd1: rsp = head.r1;
         2'd2: rsp = head.r2;
         default: rsp = head.r3;
      endcase
      more   = (sub_ff != 2'd3) && head.valid[sub_ff + 2'd1];
      wp_in  = wp_ff + 3'(wr && !full && wdata.valid[0]);
      rp_in  = rp_ff; sub_in = sub_ff;
      if (pop && has_any) begin
         if (more) sub_in = sub_ff + 2'd1;
         else begin sub_in = '0; rp_in = rp_ff + 3'd1; end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; sub_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr && !full && wdata.valid[0]) mem_ff[wp_ff[1:0]] <= wdata;
   end
endmodule

[rtl/core/token_scanner_with_statement_split.sv]
// Top level of the token scanner: front-end scanner feeding a result queue.
// Depends on tss_pkg, tss_front, tss_back.
//
//  channel | ports                   | transaction when
//  input   | req_data, push, full    | push && !full
//  result  | rsp_data, pop, empty    | pop && !empty
//
// One byte per cycle enters the scanner while full is low; it emits up to four results per byte.
// A byte's bundle is registered in the queue and reaches the result ports once earlier results are popped.
// Results sit in a four-entry bundle queue and leave one per pop, so a byte
// with several results takes that many pops on the result side.
// Reset is synchronous, active high; it clears scanner state and the queue.
// full rises only when the queue holds four bundles; input then stalls.
`timescale 1ns / 1ps
module token_scanner_with_statement_split #(
   parameter int POSITION_BITS = 32,
   parameter int DEPTH_BITS    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  tss_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output tss_pkg::rsp_type rsp_data
);
   import tss_pkg::*;

   bundle_type bundle;
   logic       step;

   // Advance the scanner on every accepted byte.
   assign step = push && !full;

   tss_front #(.POSITION_BITS(POSITION_BITS), .DEPTH_BITS(DEPTH_BITS)) u_front (
      .clock(clock), .reset(reset), .step(step), .req(req_data), .bundle(bundle)
   );

   // Queue bundles that carry at least one result; drop empty ones.
   tss_back u_back (
      .clock(clock), .reset(reset), .wr(step), .wdata(bundle), .full(full),
      .empty(empty), .rsp(rsp_data), .pop(pop)
   );
endmodule

[rtl/core/tss_checker.sv]
// Port-level checker for the token scanner, bound to the top level.
// Depends on tss_pkg.
`timescale 1ns / 1ps
module tss_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input tss_pkg::rsp_type rsp_data
);
   import tss_pkg::*;

   a_err_len: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.token_kind == K_ERROR |-> rsp_data.token_length == 32'd0)
      else $error("error result with nonzero length");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.token_kind != K_ERROR |-> rsp_data.error_code == E_NONE)
      else $error("token carries error code");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("result changed while stalled");
   a_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("queue full but shows no result");
   a_reset: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queue not cleared by reset");
endmodule

bind token_scanner_with_statement_split tss_port_checker u_checker (
   .clock(clock), .reset(reset), .full(full), .empty(empty),
   .pop(pop), .rsp_data(rsp_data)
);
